// ----- sv/btbtl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package btbtl_pkg;

   // default sizes of the predictor
   localparam int ROWS_DEF        = 32;
   localparam int MAX_HISTORY_DEF = 8;
   localparam int MAX_TAG_DEF     = 30;

   localparam int ADDR_W      = 32;
   localparam int OPCODE_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;

   // tag, target, history and a 2-bit counter for each history value, per table entry
   localparam int ROW_WORD_W_DEF =
      MAX_TAG_DEF + ADDR_W + MAX_HISTORY_DEF + 2 * (1 << MAX_HISTORY_DEF);

   localparam int PC_WORD_LSB   = 2;
   localparam int SHARE_MID_LSB = 16;

   localparam logic [ADDR_W-1:0] PC_STEP     = 32'd4;
   localparam logic [ADDR_W-1:0] TARGET_NONE = 32'hFFFF_FFFF;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PREDICT = 2'd0,
      OP_UPDATE  = 2'd1,
      OP_REINIT  = 2'd2
   } opcode_type;

   localparam logic [1:0] SHARE_NONE = 2'd0;
   localparam logic [1:0] SHARE_LOW  = 2'd1;
   localparam logic [1:0] SHARE_MID  = 2'd2;

   localparam logic [1:0] CTR_STRONG_NOT   = 2'd0;
   localparam logic [1:0] CTR_WEAK_NOT     = 2'd1;
   localparam logic [1:0] CTR_WEAK_TAKEN   = 2'd2;
   localparam logic [1:0] CTR_STRONG_TAKEN = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LOG2     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIST_BITS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAG_BITS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_STATE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIST_GLOBAL  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_GLOBAL = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHARE_MODE   = 3'd6;

   localparam logic [2:0] RST_ROW_LOG2     = 3'd5;
   localparam logic [3:0] RST_HIST_BITS    = 4'd8;
   localparam logic [4:0] RST_TAG_BITS     = 5'd30;
   localparam logic [1:0] RST_START_STATE  = CTR_WEAK_NOT;
   localparam logic       RST_HIST_GLOBAL  = 1'b1;
   localparam logic       RST_TABLE_GLOBAL = 1'b1;
   localparam logic [1:0] RST_SHARE_MODE   = SHARE_NONE;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } row_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } ctr_ctl_type;

endpackage

`default_nettype wire

// ----- sv/btbtl_row_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btbtl_row_mem #(
   parameter int ROWS   = btbtl_pkg::ROWS_DEF,
   parameter int WORD_W = btbtl_pkg::ROW_WORD_W_DEF,
   parameter int AW     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                      clock,
   input  btbtl_pkg::row_ctl_type    ctl,
   input  logic [AW-1:0]             rd_addr,
   output logic [WORD_W-1:0]         rd_data,
   input  logic [AW-1:0]             wr_addr,
   input  logic [WORD_W-1:0]         wr_data
);
   import btbtl_pkg::*;

   logic [WORD_W-1:0] mem [ROWS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/btbtl_ctr_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btbtl_ctr_mem #(
   parameter int AW = btbtl_pkg::MAX_HISTORY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  btbtl_pkg::ctr_ctl_type    ctl,
   input  logic [AW-1:0]             rd_addr,
   output logic [1:0]                rd_data,
   input  logic [AW-1:0]             wr_addr,
   input  logic [1:0]                wr_data,
   input  logic [1:0]                clear_value
);
   import btbtl_pkg::*;

   localparam int DEPTH = 1 << AW;

   logic [1:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [1:0]       fill_ff;
   logic [1:0]       data_ff;
   logic             live_ff;

   // an entry not written since the last clear reads as the fill value
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= CTR_WEAK_NOT;
      end else begin
         valid_ff <= valid_in;
         if (ctl.clear) begin
            fill_ff <= clear_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         data_ff <= mem[rd_addr];
         live_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = live_ff ? data_ff : fill_ff;

endmodule

`default_nettype wire

// ----- sv/btb_two_level_branch_predictor_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Branch target buffer with two-level direction prediction. For an accepted item
// the row memory is read (tag, target, per-row history and per-row counter table
// in one wide word), then the shared counter memory at an address built from the
// history just read; a last step forms the result and, for an update, writes back
// the row memory and, with the global table, the shared counter memory. The
// result register frees the input side, so a new item is taken while the previous
// result waits; the next result can be produced once that register is taken. Row
// and shared counter valid bits are flip-flops cleared at once by reset or a
// reinit item, so there is no clearing pass. Configuration must be written only
// while no item is in flight; the block does not enforce it.
module btb_two_level_branch_predictor_core #(
   parameter int ROWS        = btbtl_pkg::ROWS_DEF,
   parameter int MAX_HISTORY = btbtl_pkg::MAX_HISTORY_DEF,
   parameter int MAX_TAG     = btbtl_pkg::MAX_TAG_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [btbtl_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [btbtl_pkg::ADDR_W-1:0]        req_pc,
   input  logic [btbtl_pkg::ADDR_W-1:0]        req_target_pc,
   input  logic                                req_taken,
   input  logic [btbtl_pkg::ADDR_W-1:0]        req_predicted_dst,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_predict_taken,
   output logic [btbtl_pkg::ADDR_W-1:0]        rsp_predicted_target,
   output logic [btbtl_pkg::ADDR_W-1:0]        rsp_branch_count,
   output logic [btbtl_pkg::ADDR_W-1:0]        rsp_flush_count,

   input  logic                                csr_we,
   input  logic [btbtl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [btbtl_pkg::CSR_DATA_W-1:0]    csr_data
);
   import btbtl_pkg::*;

   localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_LOG_MAX = $clog2(ROWS + 1) - 1;
   localparam int TAG_W       = (MAX_TAG > 0) ? MAX_TAG : 1;
   localparam int HW          = MAX_HISTORY;
   localparam int CTRS        = 1 << MAX_HISTORY;

   typedef struct packed {
      logic [TAG_W-1:0]      tag;
      logic [ADDR_W-1:0]     target;
      logic [HW-1:0]         hist;
      logic [CTRS-1:0][1:0]  ctrs;
   } row_word_type;

   localparam int ROW_WORD_W = $bits(row_word_type);

   // configuration
   logic [2:0] row_log2_ff;
   logic [3:0] hist_bits_ff;
   logic [4:0] tag_bits_ff;
   logic [1:0] start_state_ff;
   logic       hist_global_ff;
   logic       table_global_ff;
   logic [1:0] share_mode_ff;

   // control and architectural state
   state_type         state_ff, state_in;
   logic [ROWS-1:0]   row_valid_ff, row_valid_in;
   logic [HW-1:0]     shared_hist_ff, shared_hist_in;
   logic [ADDR_W-1:0] branches_ff, branches_in;
   logic [ADDR_W-1:0] flushes_ff, flushes_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // item and lookup payload
   logic [OPCODE_W-1:0] op_ff;
   logic [ADDR_W-1:0]   pc_ff, tgt_ff, pdst_ff;
   logic                taken_ff;
   logic [ROW_AW-1:0]   row_ff;
   logic                hit_ff;
   logic [HW-1:0]       hist_ff;
   logic [HW-1:0]       ci_ff;

   logic              rsp_taken_ff;
   logic [ADDR_W-1:0] rsp_target_ff, rsp_branch_ff, rsp_flush_ff;

   // derived configuration
   logic [2:0]        row_log2_eff;
   logic [4:0]        tag_bits_eff;
   logic [3:0]        hist_len;
   logic [HW-1:0]     hist_mask;
   logic [ROW_AW-1:0] req_row;
   logic [TAG_W-1:0]  item_tag;

   logic              req_fire, exec_go;
   logic              is_predict, is_update, is_reinit;

   logic [ROW_WORD_W-1:0] row_rd_data, row_wr_data;
   row_word_type          row_rd, row_wr;
   row_ctl_type           row_ctl;
   ctr_ctl_type           ctr_ctl;
   logic [1:0]            ctr_rd;

   logic              look_hit;
   logic [HW-1:0]     look_hist, share_bits, look_ci;

   logic [1:0]        cur_ctr, ctr_new;
   logic [HW-1:0]     hist_new;
   logic [ADDR_W-1:0] pc_next;
   logic              pred_taken, flush;
   logic [CTRS-1:0][1:0] fill_ctrs;

   assign req_fire   = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign exec_go    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign is_predict = (op_ff == OP_PREDICT);
   assign is_update  = (op_ff == OP_UPDATE);
   assign is_reinit  = (op_ff == OP_REINIT);

   // clamp oversized settings; a history length of zero is raised to one
   assign row_log2_eff = (row_log2_ff > 3'(ROW_LOG_MAX)) ? 3'(ROW_LOG_MAX) : row_log2_ff;
   assign tag_bits_eff = (tag_bits_ff > 5'(MAX_TAG)) ? 5'(MAX_TAG) : tag_bits_ff;
   assign hist_len     = (hist_bits_ff == 4'd0) ? 4'd1 :
                         ((hist_bits_ff > 4'(HW)) ? 4'(HW) : hist_bits_ff);

   always_comb begin
      for (int i = 0; i < HW; i++) begin
         hist_mask[i] = (4'(i) < hist_len);
      end
      for (int i = 0; i < ROW_AW; i++) begin
         req_row[i] = req_pc[PC_WORD_LSB + i] & (3'(i) < row_log2_eff);
      end
      for (int i = 0; i < TAG_W; i++) begin
         item_tag[i] = pc_ff[PC_WORD_LSB + i] & (5'(i) < tag_bits_eff);
      end
   end

   // lookup: row word is on the memory output
   assign row_rd = row_rd_data;

   always_comb begin
      look_hit  = row_valid_ff[row_ff] && (row_rd.tag == item_tag);
      look_hist = (hist_global_ff ? shared_hist_ff : (look_hit ? row_rd.hist : '0))
                  & hist_mask;
      case (share_mode_ff)
         SHARE_LOW: share_bits = pc_ff[PC_WORD_LSB +: HW];
         SHARE_MID: share_bits = pc_ff[SHARE_MID_LSB +: HW];
         default:   share_bits = '0;
      endcase
      // share only applies to the global table
      look_ci = look_hist ^ (table_global_ff ? (share_bits & hist_mask) : '0);
   end

   // execute: counter and row word are both on the memory outputs
   assign fill_ctrs = {CTRS{start_state_ff}};
   assign pc_next   = pc_ff + PC_STEP;

   always_comb begin
      if (table_global_ff) begin
         cur_ctr = ctr_rd;
      end else begin
         cur_ctr = hit_ff ? row_rd.ctrs[ci_ff] : start_state_ff;
      end
      pred_taken = hit_ff && (row_rd.target != TARGET_NONE) && (cur_ctr >= CTR_WEAK_TAKEN);
      if (taken_ff) begin
         ctr_new = (cur_ctr == CTR_STRONG_TAKEN) ? cur_ctr : cur_ctr + 2'd1;
      end else begin
         ctr_new = (cur_ctr == CTR_STRONG_NOT) ? cur_ctr : cur_ctr - 2'd1;
      end
      hist_new = ((hist_ff << 1) | HW'(taken_ff)) & hist_mask;
      flush    = taken_ff ? (pdst_ff != tgt_ff) : (pdst_ff != pc_next);

      // reallocate on a miss, keep the target on a hit
      row_wr.tag    = item_tag;
      row_wr.target = hit_ff ? row_rd.target : tgt_ff;
      row_wr.hist   = hist_global_ff ? (hit_ff ? row_rd.hist : '0) : hist_new;
      row_wr.ctrs   = hit_ff ? row_rd.ctrs : fill_ctrs;
      if (!table_global_ff) begin
         row_wr.ctrs[ci_ff] = ctr_new;
      end
   end

   assign row_wr_data   = row_wr;
   assign row_ctl.rd_en = req_fire;
   assign row_ctl.wr_en = exec_go && is_update;
   assign ctr_ctl.rd_en = (state_ff == ST_LOOK);
   assign ctr_ctl.wr_en = exec_go && is_update && table_global_ff;
   assign ctr_ctl.clear = exec_go && is_reinit;

   btbtl_row_mem #(
      .ROWS   (ROWS),
      .WORD_W (ROW_WORD_W),
      .AW     (ROW_AW)
   ) u_row_mem (
      .clock   (clock),
      .ctl     (row_ctl),
      .rd_addr (req_row),
      .rd_data (row_rd_data),
      .wr_addr (row_ff),
      .wr_data (row_wr_data)
   );

   btbtl_ctr_mem #(
      .AW (HW)
   ) u_ctr_mem (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctr_ctl),
      .rd_addr     (look_ci),
      .rd_data     (ctr_rd),
      .wr_addr     (ci_ff),
      .wr_data     (ctr_new),
      .clear_value (start_state_ff)
   );

   // next state of control and counts
   always_comb begin
      state_in       = state_ff;
      row_valid_in   = row_valid_ff;
      shared_hist_in = shared_hist_ff;
      branches_in    = branches_ff;
      flushes_in     = flushes_ff;
      rsp_valid_in   = rsp_ready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (exec_go) begin
         case (op_ff)
            OP_UPDATE: begin
               branches_in          = branches_ff + 32'd1;
               flushes_in           = flush ? flushes_ff + 32'd1 : flushes_ff;
               row_valid_in[row_ff] = 1'b1;
               if (hist_global_ff) begin
                  shared_hist_in = hist_new;
               end
            end
            OP_REINIT: begin
               row_valid_in   = '0;
               shared_hist_in = '0;
               branches_in    = '0;
               flushes_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         row_valid_ff    <= '0;
         shared_hist_ff  <= '0;
         branches_ff     <= '0;
         flushes_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         row_log2_ff     <= RST_ROW_LOG2;
         hist_bits_ff    <= RST_HIST_BITS;
         tag_bits_ff     <= RST_TAG_BITS;
         start_state_ff  <= RST_START_STATE;
         hist_global_ff  <= RST_HIST_GLOBAL;
         table_global_ff <= RST_TABLE_GLOBAL;
         share_mode_ff   <= RST_SHARE_MODE;
      end else begin
         state_ff       <= state_in;
         row_valid_ff   <= row_valid_in;
         shared_hist_ff <= shared_hist_in;
         branches_ff    <= branches_in;
         flushes_ff     <= flushes_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROW_LOG2:     row_log2_ff     <= csr_data[2:0];
               CSR_HIST_BITS:    hist_bits_ff    <= csr_data[3:0];
               CSR_TAG_BITS:     tag_bits_ff     <= csr_data[4:0];
               CSR_START_STATE:  start_state_ff  <= csr_data[1:0];
               CSR_HIST_GLOBAL:  hist_global_ff  <= csr_data[0];
               CSR_TABLE_GLOBAL: table_global_ff <= csr_data[0];
               CSR_SHARE_MODE:   share_mode_ff   <= csr_data[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_opcode;
         pc_ff    <= req_pc;
         tgt_ff   <= req_target_pc;
         taken_ff <= req_taken;
         pdst_ff  <= req_predicted_dst;
         row_ff   <= req_row;
      end
      if (state_ff == ST_LOOK) begin
         hit_ff  <= look_hit;
         hist_ff <= look_hist;
         ci_ff   <= look_ci;
      end
      if (exec_go) begin
         rsp_taken_ff  <= is_predict && pred_taken;
         rsp_target_ff <= is_predict ? (pred_taken ? row_rd.target : pc_next) : '0;
         rsp_branch_ff <= branches_in;
         rsp_flush_ff  <= flushes_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predict_taken    = rsp_taken_ff;
   assign rsp_predicted_target = rsp_target_ff;
   assign rsp_branch_count     = rsp_branch_ff;
   assign rsp_flush_count      = rsp_flush_ff;

endmodule

`default_nettype wire

// ----- sv/btbtl_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module btbtl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_predict_taken,
   input logic [btbtl_pkg::ADDR_W-1:0]  rsp_predicted_target,
   input logic [btbtl_pkg::ADDR_W-1:0]  rsp_branch_count,
   input logic [btbtl_pkg::ADDR_W-1:0]  rsp_flush_count
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_predict_taken) && $stable(rsp_predicted_target) &&
         $stable(rsp_branch_count) && $stable(rsp_flush_count))
      else $error("result payload changed while stalled");

   // one item in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again while an item is in flight");

   // lookup takes at least two memory reads before a result
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after acceptance");

endmodule

bind btb_two_level_branch_predictor_core btbtl_checker u_checker (.*);

`default_nettype wire
